### rtl/qes_pkg.sv
// ----------------------------------------------------------------------------
// qes_pkg
// Shared types and constants of the quadrature encoder speed block.
// ----------------------------------------------------------------------------
`default_nettype none

package qes_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TickW  = 32;
  localparam int unsigned TdistW = 10;
  localparam int unsigned DistW  = TickW + TdistW;   // 42
  localparam int unsigned SpeedW = 32;
  localparam int unsigned ScaleW = 10;
  localparam int unsigned NumW   = DistW + ScaleW;   // 52, |diff| * 1000

  localparam logic [ScaleW-1:0] SpeedScale = ScaleW'(1000);

  localparam logic [TdistW-1:0] TickDistReset  = TdistW'(325);
  localparam logic [TimeW-1:0]  WindowReset    = TimeW'(10000);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  typedef enum logic {
    REG_TICK_DIST = 1'b0,
    REG_WINDOW    = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_PREP,
    ST_MULT,
    ST_DIV,
    ST_SAT,
    ST_EMIT
  } state_e;

  // One classified item between front and back
  typedef struct packed {
    op_e              op;
    dir_e             dir;
    logic             bad;
    logic [TimeW-1:0] time_us;
  } item_t;

endpackage

`default_nettype wire

### rtl/quadrature_encoder_speed.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_speed
// Quadrature decoder with tick counts, distance and windowed speed.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per transfer; tuser = operation (sample or clear),
//   tdata = pin_a, pin_b, time_us. Master stream: one result per item.
//   Configuration: write tick distance (index 0) or speed window (index 1)
//   while the block is idle; takes effect on the next item.
// Processing:
//   The front classifies an item on its transfer and parks it in a
//   two-entry queue. The back takes one item at a time: a clear or a sample
//   with no tick goes from idle to emit; a tick adds distance and prep, and
//   one that closes the speed window adds multiply, a serial divide with
//   one quotient bit per cycle (52 bits) and saturate. The back pops the
//   next item the cycle after a result is loaded.
// Reset:
//   Counters, pins, held distance, speed and window start clear to zero;
//   registers return to 325 um per tick and a 10000 us window.
// Stall:
//   A result waits in the output register; the back holds, the queue fills
//   and then tready drops on the slave side.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_speed (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // pin_a, pin_b, time_us[31:0], zero pad
  input  wire logic        s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // step_dir[1:0], bad_transition,
                                           // distance_um[41:0], speed_mm_s[31:0],
                                           // speed_updated, zero pad
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic [qes_pkg::TdistW-1:0] tick_dist_q;
  logic [qes_pkg::TimeW-1:0]  window_q;

  logic            push, q_full, q_valid, pop;
  qes_pkg::item_t  item_in, item_out;

  qes_pkg::dir_e                 out_dir;
  logic                          out_bad, out_upd;
  logic [qes_pkg::DistW-1:0]     out_dist;
  logic [qes_pkg::SpeedW-1:0]    out_speed;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_dist_q <= qes_pkg::TickDistReset;
      window_q    <= qes_pkg::WindowReset;
    end else if (cfg_we_i) begin
      unique case (qes_pkg::reg_e'(cfg_index_i))
        qes_pkg::REG_TICK_DIST: tick_dist_q <= cfg_wdata_i[qes_pkg::TdistW-1:0];
        qes_pkg::REG_WINDOW:    window_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: classify each sample against the previous pin pair
  qes_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .op_i      (qes_pkg::op_e'(s_axis_tuser)),
    .pin_a_i   (s_axis_tdata[0]),
    .pin_b_i   (s_axis_tdata[1]),
    .time_us_i (s_axis_tdata[33:2]),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (item_in)
  );

  // Queue: lets the front keep taking transfers while the back divides
  qes_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (item_in),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (item_out)
  );

  // Back: counters, distance, speed, result register
  qes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_dist_i(tick_dist_q),
    .window_i   (window_q),
    .q_valid_i  (q_valid),
    .q_data_i   (item_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_dir_o  (out_dir),
    .out_bad_o  (out_bad),
    .out_dist_o (out_dist),
    .out_speed_o(out_speed),
    .out_upd_o  (out_upd)
  );

  assign m_axis_tdata = {2'b00, out_upd, out_speed, out_dist, out_bad, out_dir};

  // Never take an item out of an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");

  // A speed update only follows a counted tick
  a_upd_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_upd) |-> (out_dir != qes_pkg::DIR_NONE))
    else $error("speed update without tick");

  // A bad transition never carries a tick
  a_bad_notick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_bad) |-> (out_dir == qes_pkg::DIR_NONE && !out_upd))
    else $error("bad transition with tick");

endmodule

`default_nettype wire

### rtl/qes_front.sv
// ----------------------------------------------------------------------------
// qes_front
// Accepts samples, compares them with the previous pin pair, classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module qes_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire qes_pkg::op_e               op_i,
  input  wire logic                       pin_a_i,
  input  wire logic                       pin_b_i,
  input  wire logic [qes_pkg::TimeW-1:0]  time_us_i,
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output qes_pkg::item_t                  item_o
);

  logic last_a_q, last_a_d, last_b_q, last_b_d;
  logic fwd, bwd, moved;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    fwd   = (pin_a_i == last_a_q && pin_b_i != last_b_q && pin_b_i == pin_a_i) ||
            (last_a_q == last_b_q && pin_a_i != last_a_q);
    bwd   = (pin_b_i == last_b_q && pin_a_i != last_a_q && pin_a_i == pin_b_i) ||
            (last_a_q == last_b_q && pin_b_i != last_b_q);
    moved = (pin_a_i != last_a_q) || (pin_b_i != last_b_q);

    item_o.op      = op_i;
    item_o.time_us = time_us_i;
    item_o.dir     = qes_pkg::DIR_NONE;
    item_o.bad     = 1'b0;
    if (op_i == qes_pkg::OP_SAMPLE) begin
      priority if (fwd) begin
        item_o.dir = qes_pkg::DIR_FWD;
      end else if (bwd) begin
        item_o.dir = qes_pkg::DIR_BWD;
      end else begin
        item_o.bad = moved;
      end
    end

    last_a_d = last_a_q;
    last_b_d = last_b_q;
    if (push_o && op_i == qes_pkg::OP_SAMPLE) begin
      last_a_d = pin_a_i;
      last_b_d = pin_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      last_b_q <= 1'b0;
    end else begin
      last_a_q <= last_a_d;
      last_b_q <= last_b_d;
    end
  end

endmodule

`default_nettype wire

### rtl/qes_queue.sv
// ----------------------------------------------------------------------------
// qes_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module qes_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire qes_pkg::item_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output qes_pkg::item_t       data_o
);

  qes_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/qes_div.sv
// ----------------------------------------------------------------------------
// qes_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qes_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [qes_pkg::NumW-1:0]    num_i,
  input  wire logic [qes_pkg::TimeW-1:0]   den_i,
  output logic                             done_o,
  output logic [qes_pkg::NumW-1:0]         quo_o
);

  localparam int unsigned CntW = $clog2(qes_pkg::NumW + 1);

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [qes_pkg::TimeW:0]    rem_q, rem_d, rem_sh;
  logic [qes_pkg::NumW-1:0]   quo_q, quo_d;
  logic [qes_pkg::TimeW-1:0]  den_q, den_d;
  logic                       fit;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_comb begin
    rem_sh = {rem_q[qes_pkg::TimeW-1:0], quo_q[qes_pkg::NumW-1]};
    fit    = rem_sh >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CntW'(qes_pkg::NumW);
    end else if (cnt_q != '0) begin
      rem_d  = fit ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d  = {quo_q[qes_pkg::NumW-2:0], fit};
      cnt_d  = cnt_q - CntW'(1);
      done_d = cnt_q == CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

endmodule

`default_nettype wire

### rtl/qes_back.sv
// ----------------------------------------------------------------------------
// qes_back
// Tick counters, distance, windowed speed and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qes_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [qes_pkg::TdistW-1:0]  tick_dist_i,
  input  wire logic [qes_pkg::TimeW-1:0]   window_i,
  input  wire logic                        q_valid_i,
  input  wire qes_pkg::item_t              q_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output qes_pkg::dir_e                    out_dir_o,
  output logic                             out_bad_o,
  output logic [qes_pkg::DistW-1:0]        out_dist_o,
  output logic [qes_pkg::SpeedW-1:0]       out_speed_o,
  output logic                             out_upd_o
);

  localparam int unsigned DistW = qes_pkg::DistW;
  localparam int unsigned TickW = qes_pkg::TickW;
  localparam int unsigned TimeW = qes_pkg::TimeW;
  localparam int unsigned SpeedW = qes_pkg::SpeedW;
  localparam int unsigned NumW = qes_pkg::NumW;

  qes_pkg::state_e state_q, state_d;

  logic [TickW-1:0]  fwd_q, bwd_q;
  logic [DistW-1:0]  held_dist_q, wsd_q, dist_q, mag_q;
  logic [SpeedW-1:0] held_speed_q;
  logic [TimeW-1:0]  wst_q, time_q, elapsed;
  logic              neg_q;
  qes_pkg::dir_e     dir_q;
  logic              bad_q, upd_q;

  logic              out_valid_q;
  qes_pkg::dir_e     out_dir_q;
  logic              out_bad_q, out_upd_q;
  logic [DistW-1:0]  out_dist_q;
  logic [SpeedW-1:0] out_speed_q;

  logic              div_start, div_done, out_load, out_free;
  logic [NumW-1:0]   div_quo, num;
  logic [TickW-1:0]  larger;
  logic [SpeedW-1:0] sat;

  qes_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (elapsed),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    elapsed  = time_q - wst_q;
    larger   = (fwd_q >= bwd_q) ? fwd_q : bwd_q;
    num      = NumW'(mag_q) * NumW'(qes_pkg::SpeedScale);
    out_free = !out_valid_q || out_ready_i;
    // Saturate the signed quotient to the 32-bit range
    if (neg_q) begin
      sat = (div_quo >= NumW'(64'h8000_0000)) ? SpeedW'(32'h8000_0000)
                                               : SpeedW'(-div_quo[SpeedW-1:0]);
    end else begin
      sat = (div_quo > NumW'(64'h7FFF_FFFF)) ? SpeedW'(32'h7FFF_FFFF)
                                              : div_quo[SpeedW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qes_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_data_i.op == qes_pkg::OP_SAMPLE && q_data_i.dir != qes_pkg::DIR_NONE)
                    ? qes_pkg::ST_DIST : qes_pkg::ST_EMIT;
        end
      end
      qes_pkg::ST_DIST: state_d = qes_pkg::ST_PREP;
      qes_pkg::ST_PREP: state_d = (elapsed > window_i) ? qes_pkg::ST_MULT : qes_pkg::ST_EMIT;
      qes_pkg::ST_MULT: state_d = qes_pkg::ST_DIV;
      qes_pkg::ST_DIV:  state_d = div_done ? qes_pkg::ST_SAT : qes_pkg::ST_DIV;
      qes_pkg::ST_SAT:  state_d = qes_pkg::ST_EMIT;
      qes_pkg::ST_EMIT: state_d = out_free ? qes_pkg::ST_IDLE : qes_pkg::ST_EMIT;
      default:          state_d = qes_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      qes_pkg::ST_IDLE: pop_o     = q_valid_i;
      qes_pkg::ST_MULT: div_start = 1'b1;
      qes_pkg::ST_EMIT: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= qes_pkg::ST_IDLE;
      fwd_q        <= '0;
      bwd_q        <= '0;
      held_dist_q  <= '0;
      held_speed_q <= '0;
      wst_q        <= '0;
      wsd_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        if (q_data_i.op == qes_pkg::OP_CLEAR) begin
          fwd_q <= '0;
          bwd_q <= '0;
        end else if (q_data_i.dir == qes_pkg::DIR_FWD) begin
          fwd_q <= fwd_q + TickW'(1);
        end else if (q_data_i.dir == qes_pkg::DIR_BWD) begin
          bwd_q <= bwd_q + TickW'(1);
        end
      end
      if (state_q == qes_pkg::ST_PREP) begin
        held_dist_q <= dist_q;
      end
      if (state_q == qes_pkg::ST_SAT) begin
        held_speed_q <= sat;
        wst_q        <= time_q;
        wsd_q        <= dist_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      time_q <= q_data_i.time_us;
      dir_q  <= (q_data_i.op == qes_pkg::OP_CLEAR) ? qes_pkg::DIR_NONE : q_data_i.dir;
      bad_q  <= (q_data_i.op == qes_pkg::OP_CLEAR) ? 1'b0 : q_data_i.bad;
      upd_q  <= 1'b0;
    end
    if (state_q == qes_pkg::ST_DIST) begin
      dist_q <= DistW'(larger) * DistW'(tick_dist_i);
    end
    if (state_q == qes_pkg::ST_PREP) begin
      neg_q <= dist_q < wsd_q;
      mag_q <= (dist_q < wsd_q) ? wsd_q - dist_q : dist_q - wsd_q;
    end
    if (state_q == qes_pkg::ST_SAT) begin
      upd_q <= 1'b1;
    end
    if (out_load) begin
      out_dir_q   <= dir_q;
      out_bad_q   <= bad_q;
      out_dist_q  <= held_dist_q;
      out_speed_q <= held_speed_q;
      out_upd_q   <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dir_o   = out_dir_q;
  assign out_bad_o   = out_bad_q;
  assign out_dist_o  = out_dist_q;
  assign out_speed_o = out_speed_q;
  assign out_upd_o   = out_upd_q;

endmodule

`default_nettype wire

### bench/quadrature_encoder_speed_test.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_speed_test
// Self-checking bench for the quadrature decoder with distance and speed.
// Items go in through the slave stream. A local model of the decoder
// predicts each result, and every result that leaves the master stream is
// checked against it. The run covers directed pin transitions, clears and
// window edges, then random encoder walks under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module quadrature_encoder_speed_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Expected content of one result transfer
  typedef struct packed {
    qes_pkg::dir_e dir;
    logic          bad;
    logic [41:0]   dist_um;
    logic [31:0]   speed;
    logic          upd;
  } enc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // pin_a, pin_b, time_us[31:0], zero pad
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // step_dir[1:0], bad_transition, distance_um[41:0],
                               // speed_mm_s[31:0], speed_updated, zero pad
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_wdata_i;

  quadrature_encoder_speed uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Decoder model state and its copy of the registers
  logic [9:0]         mdl_tick_um;
  logic [31:0]        mdl_window_us;
  logic               mdl_prev_a, mdl_prev_b;
  logic [31:0]        mdl_fwd_ticks, mdl_bwd_ticks;
  logic [63:0]        mdl_distance;
  logic signed [31:0] mdl_speed;
  logic [31:0]        mdl_win_time;
  logic [63:0]        mdl_win_distance;

  enc_result_t pending_results[$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          speed_updates;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] walk_time;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Timeout at %0t", $time);
    $display("CHECK FAILED");
    $finish;
  end

  // Advance the model by one item and return the result it predicts
  function automatic enc_result_t decode_item(qes_pkg::op_e op, logic a, logic b,
                                              logic [31:0] now);
    enc_result_t        r;
    logic               fwd, bwd;
    logic [31:0]        larger, elapsed;
    logic signed [63:0] diff, quot;
    r = '0;
    r.dir = qes_pkg::DIR_NONE;
    if (op == qes_pkg::OP_CLEAR) begin
      mdl_fwd_ticks = '0;
      mdl_bwd_ticks = '0;
    end else begin
      fwd = (a == mdl_prev_a && b != mdl_prev_b && b == a) ||
            (mdl_prev_a == mdl_prev_b && a != mdl_prev_a);
      bwd = (b == mdl_prev_b && a != mdl_prev_a && a == b) ||
            (mdl_prev_a == mdl_prev_b && b != mdl_prev_b);
      if (fwd || bwd) begin
        if (fwd) begin
          r.dir = qes_pkg::DIR_FWD;
          mdl_fwd_ticks = mdl_fwd_ticks + 32'd1;
        end else begin
          r.dir = qes_pkg::DIR_BWD;
          mdl_bwd_ticks = mdl_bwd_ticks + 32'd1;
        end
        larger = (mdl_fwd_ticks >= mdl_bwd_ticks) ? mdl_fwd_ticks : mdl_bwd_ticks;
        mdl_distance = 64'(larger) * 64'(mdl_tick_um);
        elapsed = now - mdl_win_time;
        if (elapsed > mdl_window_us) begin
          diff = $signed(mdl_distance) - $signed(mdl_win_distance);
          quot = (diff * 64'sd1000) / $signed({32'd0, elapsed});
          if (quot > 64'sd2147483647) quot = 64'sd2147483647;
          if (quot < -64'sd2147483648) quot = -64'sd2147483648;
          mdl_speed = quot[31:0];
          mdl_win_time = now;
          mdl_win_distance = mdl_distance;
          r.upd = 1'b1;
        end
      end else if (!(a == mdl_prev_a && b == mdl_prev_b)) begin
        r.bad = 1'b1;
      end
      mdl_prev_a = a;
      mdl_prev_b = b;
    end
    r.dist_um = mdl_distance[41:0];
    r.speed   = mdl_speed;
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then maybe idle
  task automatic send_item(qes_pkg::op_e op, logic a, logic b, logic [31:0] now);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, now, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(decode_item(op, a, b, now));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop tvalid, let every expected result arrive, then let the back settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(qes_pkg::reg_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == qes_pkg::REG_TICK_DIST) mdl_tick_um = value[9:0];
    else mdl_window_us = value;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [9:0] tick_um, logic [31:0] window_us);
    write_reg(qes_pkg::REG_TICK_DIST, {22'd0, tick_um});
    write_reg(qes_pkg::REG_WINDOW, window_us);
  endtask

  // Receiver side: stall at the current rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    enc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.dir     = qes_pkg::dir_e'(m_axis_tdata[1:0]);
      got.bad     = m_axis_tdata[2];
      got.dist_um = m_axis_tdata[44:3];
      got.speed   = m_axis_tdata[76:45];
      got.upd     = m_axis_tdata[77];
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result dir=%0d bad=%0d dist=%0d speed=%0d upd=%0d",
                 $time, got.dir, got.bad, got.dist_um, $signed(got.speed), got.upd);
      end else begin
        want = pending_results.pop_front();
        if (got.upd) speed_updates++;
        if (got !== want) begin
          error_count++;
          $display("%0t: mismatch expected dir=%0d bad=%0d dist=%0d speed=%0d upd=%0d",
                   $time, want.dir, want.bad, want.dist_um, $signed(want.speed), want.upd);
          $display("%0t:          actual dir=%0d bad=%0d dist=%0d speed=%0d upd=%0d",
                   $time, got.dir, got.bad, got.dist_um, $signed(got.speed), got.upd);
        end
      end
    end
  end

  // Forward order of the pin pair (a,b): 00, 10, 11, 01
  function automatic logic [1:0] gray_ab(int k);
    case (k & 3)
      0: return 2'b00;
      1: return 2'b10;
      2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic int gray_pos(logic a, logic b);
    for (int k = 0; k < 4; k++) if (gray_ab(k) == {a, b}) return k;
    return 0;
  endfunction

  // Clears, every kind of pin change and the timestamp extremes
  task automatic test_transitions();
    logic [1:0] ab;
    send_item(qes_pkg::OP_CLEAR, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(qes_pkg::OP_SAMPLE, 1'b0, 1'b0, 32'd0);          // no change
    for (int k = 1; k <= 4; k++) begin                         // forward lap
      ab = gray_ab(k);
      send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], 32'd4000 * k);
    end
    for (int k = 3; k >= 0; k--) begin                         // backward lap
      ab = gray_ab(k);
      send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], 32'd20000 + 32'd6000 * (4 - k));
    end
    // both pins flip: forward from an equal pair, neither direction from 10 to 01
    send_item(qes_pkg::OP_SAMPLE, 1'b1, 1'b1, 32'd50000);
    send_item(qes_pkg::OP_SAMPLE, 1'b0, 1'b0, 32'd50001);
    send_item(qes_pkg::OP_SAMPLE, 1'b1, 1'b0, 32'd50002);
    send_item(qes_pkg::OP_SAMPLE, 1'b0, 1'b1, 32'd50003);
    send_item(qes_pkg::OP_CLEAR, 1'b0, 1'b0, 32'd0);
    send_item(qes_pkg::OP_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFFF);  // no change after a clear
  endtask

  // Zero window, timestamp wrap, falling distance after a clear, zero tick size
  task automatic test_window_edges();
    logic [1:0] ab;
    int         pos;
    pos = gray_pos(mdl_prev_a, mdl_prev_b);
    for (int k = 1; k <= 4; k++) begin
      ab = gray_ab(pos + k);
      send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], 32'hFFFF_FFF0 + 32'd5 * k);
    end
    send_item(qes_pkg::OP_CLEAR, 1'b0, 1'b0, 32'd0);
    ab = gray_ab(pos + 3);
    send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], 32'd40);       // negative speed
    drain();
    write_reg(qes_pkg::REG_TICK_DIST, 32'd0);
    ab = gray_ab(pos + 4);
    send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], 32'd41);
  endtask

  // Random walks along the encoder pattern, with noise, clears and jumps
  task automatic run_random(int count, int s_pct, int r_pct);
    int         pick, pos, heading;
    logic [1:0] ab;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    heading = 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      pos  = gray_pos(mdl_prev_a, mdl_prev_b);
      if ($urandom_range(99) < 95) walk_time = walk_time + $urandom_range(0, 3000);
      else walk_time = $urandom;
      if (pick < 80) begin
        if ($urandom_range(99) < 8) heading = -heading;
        ab = gray_ab(pos + heading + 4);
        send_item(qes_pkg::OP_SAMPLE, ab[1], ab[0], walk_time);
      end else if (pick < 87) begin
        send_item(qes_pkg::OP_SAMPLE, mdl_prev_a, mdl_prev_b, walk_time);
      end else if (pick < 92) begin
        send_item(qes_pkg::OP_SAMPLE, !mdl_prev_a, !mdl_prev_b, walk_time);
      end else if (pick < 96) begin
        send_item(qes_pkg::OP_CLEAR, 1'($urandom), 1'($urandom), $urandom);
      end else begin
        send_item(qes_pkg::op_e'(1'($urandom)), 1'($urandom), 1'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_wdata_i   = '0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    speed_updates = 0;
    send_idle_pct = 13;
    recv_idle_pct = 67;
    walk_time     = '0;
    mdl_tick_um   = 10'd325;
    mdl_window_us = 32'd10000;
    mdl_prev_a    = 1'b0;
    mdl_prev_b    = 1'b0;
    mdl_fwd_ticks = '0;
    mdl_bwd_ticks = '0;
    mdl_distance  = '0;
    mdl_speed     = '0;
    mdl_win_time  = '0;
    mdl_win_distance = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_transitions();          // reset register values
    drain();
    configure(10'd1023, 32'd0);
    test_window_edges();
    drain();

    configure(10'd325, 32'd10000);
    run_random(450, 13, 67);
    drain();
    configure(10'd1, 32'hFFFF_FFFF);
    run_random(150, 67, 13);
    drain();
    configure(10'd0, 32'd50);
    run_random(150, 67, 13);
    drain();
    configure(10'($urandom_range(1, 1023)), $urandom_range(0, 20000));
    run_random(450, 0, 0);
    drain();
    configure(10'd1023, 32'd0);
    run_random(150, 0, 0);
    drain();

    $display("Sent %0d items, checked %0d results, %0d with a speed update",
             items_sent, results_seen, speed_updates);
    $display("Covered pin transitions, clears, timestamp wrap and six register settings");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/qes_pkg.sv
rtl/qes_front.sv
rtl/qes_queue.sv
rtl/qes_div.sv
rtl/qes_back.sv
rtl/quadrature_encoder_speed.sv
bench/quadrature_encoder_speed_test.sv
